// ----- sv/pbo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_pkg
// shared types and constants for the breathing-pulse opacity generator
// ----------------------------------------------------------------------------
package pbo_pkg;

  // timestamp width, fixed by the payload format
  localparam int TimeBits        = 32;
  // default countdown width
  localparam int FrameBitsDef    = 16;
  // configuration register widths
  localparam int TotalBits       = 16;
  localparam int CfgDataBits     = 16;
  localparam int CfgIdxBits      = 2;
  // opacity scale: dist * 510 / N
  localparam int ScaleShiftHi    = 9;
  localparam int ScaleShiftLo    = 1;
  localparam int OpacityBits     = 8;
  // dividend width for dist * 510
  localparam int DivBits         = TotalBits + ScaleShiftHi;

  // register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_ANIM_ENABLED = 2'd0,
    REG_FRAME_TOTAL  = 2'd1,
    REG_FRAME_PERIOD = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  // input item kinds
  typedef enum logic {
    KIND_PLAY = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                kind;
    logic                play_request;
    logic [TimeBits-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic                   advanced;
    logic [OpacityBits-1:0] opacity;
    logic                   is_playing;
  } out_t;

endpackage

// ----- sv/pulse_breathing_opacity.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_breathing_opacity
// breathing-pulse frame countdown with triangular opacity output
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (pbo_pkg::in_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (pbo_pkg::out_t)
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
//  an item passes through the states in order: ST_EXEC updates the countdown state,
//  ST_PREP forms dist * 510, ST_DIV runs a shared shift/compare/subtract divider
//  (one quotient bit each step), ST_OUT loads the output register, and ST_IDLE
//  takes the next item
//  the output register lets a new item in while a result still waits; the
//  block only stalls in its last step if the previous result was not taken
//  reset is asynchronous and active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module pulse_breathing_opacity #(
  parameter int FRAME_BITS = pbo_pkg::FrameBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pbo_pkg::in_t                        in_data_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pbo_pkg::out_t                       out_data_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [pbo_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [pbo_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  import pbo_pkg::*;

  // compare width covering both the countdown and frame_total
  localparam int NW = (FRAME_BITS > TotalBits) ? FRAME_BITS : TotalBits;
  localparam int CntBits = $clog2(OpacityBits);

  // configuration registers
  logic                 anim_enabled_q;
  logic [TotalBits-1:0] frame_total_q;
  logic [TotalBits-1:0] frame_period_q;

  // animation state
  logic                  playing_q, playing_d;
  logic [FRAME_BITS-1:0] frames_left_q, frames_left_d;
  logic [TimeBits-1:0]   last_time_q, last_time_d;

  // captured item and per-item results
  in_t  item_q;
  logic adv_q, adv_d;

  // sequencer
  state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q;

  // divider
  logic [DivBits-1:0]     rem_q;
  logic [OpacityBits-1:0] quo_q;
  logic                   zero_q;

  // output register
  logic out_valid_q;
  out_t out_q;

  // control from the output decode
  logic do_exec, do_prep, do_div, do_out;

  logic                  enabled;
  logic [FRAME_BITS-1:0] load_total;

  assign enabled    = anim_enabled_q && (frame_total_q != '0);
  assign load_total = FRAME_BITS'(frame_total_q);

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == '0) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    do_exec    = 1'b0;
    do_prep    = 1'b0;
    do_div     = 1'b0;
    do_out     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: do_exec    = 1'b1;
      ST_PREP: do_prep    = 1'b1;
      ST_DIV:  do_div     = 1'b1;
      ST_OUT:  do_out     = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_enabled_q <= 1'b0;
      frame_total_q  <= TotalBits'(1);
      frame_period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ANIM_ENABLED: anim_enabled_q <= cfg_wdata_i[0];
        REG_FRAME_TOTAL:  frame_total_q  <= cfg_wdata_i[TotalBits-1:0];
        REG_FRAME_PERIOD: frame_period_q <= cfg_wdata_i[TotalBits-1:0];
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // state update for one item (play/stop request or time tick)
  // ---------------------------------------------------------------------------
  logic [TimeBits-1:0]   elapsed;
  logic [FRAME_BITS-1:0] tick_frames;

  always_comb begin
    playing_d     = playing_q;
    frames_left_d = frames_left_q;
    last_time_d   = last_time_q;
    adv_d         = 1'b0;
    elapsed       = item_q.now_time - last_time_q;   // wraps modulo 2^TimeBits
    tick_frames   = frames_left_q;

    if (kind_e'(item_q.kind) == KIND_PLAY) begin
      if (item_q.play_request != playing_q) begin
        playing_d = item_q.play_request;
        if (item_q.play_request) begin
          // start: reload the countdown
          frames_left_d = enabled ? load_total : '0;
          last_time_d   = item_q.now_time;
        end else if (NW'(frames_left_q) > NW'(frame_total_q >> 1)) begin
          // stop past the half-way point: run the countdown the other way
          if (NW'(frames_left_q) > NW'(frame_total_q)) begin
            frames_left_d = '0;
          end else begin
            frames_left_d = FRAME_BITS'(NW'(frame_total_q) - NW'(frames_left_q));
          end
        end
      end
    end else begin
      if (enabled && !(!playing_q && frames_left_q == '0) &&
          elapsed >= TimeBits'(frame_period_q)) begin
        // reload first while playing, then count down one frame
        if (playing_q && frames_left_q == '0) begin
          tick_frames = load_total;
        end
        if (tick_frames != '0) begin
          frames_left_d = tick_frames - FRAME_BITS'(1);
        end else begin
          frames_left_d = tick_frames;
        end
        last_time_d = item_q.now_time;
        adv_d       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q     <= 1'b0;
      frames_left_q <= '0;
      last_time_q   <= '0;
      adv_q         <= 1'b0;
    end else if (do_exec) begin
      playing_q     <= playing_d;
      frames_left_q <= frames_left_d;
      last_time_q   <= last_time_d;
      adv_q         <= adv_d;
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // opacity: dist = min(r, N - r), then dist * 510 / N by restoring division
  // ---------------------------------------------------------------------------
  logic [NW-1:0]        r_ext, n_ext, n_minus_r;
  logic [TotalBits-1:0] near_dist;
  logic [DivBits-1:0]   dividend;
  logic                 opa_zero;
  logic [DivBits-1:0]   trial;
  logic                 fits;

  always_comb begin
    r_ext     = NW'(frames_left_q);
    n_ext     = NW'(frame_total_q);
    n_minus_r = n_ext - r_ext;
    opa_zero  = !enabled || (r_ext > n_ext);
    // only meaningful when r <= N, so the distance fits in the frame_total width
    near_dist = (n_minus_r < r_ext) ? TotalBits'(n_minus_r) : TotalBits'(r_ext);
    // dist * 510 as (dist << 9) - (dist << 1)
    dividend  = (DivBits'(near_dist) << ScaleShiftHi) -
                (DivBits'(near_dist) << ScaleShiftLo);
    // shared divider step: compare against N shifted to the current bit
    trial     = DivBits'(frame_total_q) << cnt_q;
    fits      = rem_q >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (do_prep) begin
      cnt_q <= CntBits'(OpacityBits - 1);
    end else if (do_div && cnt_q != '0) begin
      cnt_q <= cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_prep) begin
      rem_q  <= dividend;
      quo_q  <= '0;
      zero_q <= opa_zero;
    end else if (do_div) begin
      if (fits) begin
        rem_q        <= rem_q - trial;
        quo_q[cnt_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // quotient never exceeds 255 since dist <= N / 2
  always_ff @(posedge clk_i) begin
    if (do_out) begin
      out_q.advanced   <= adv_q;
      out_q.opacity    <= zero_q ? '0 : quo_q;
      out_q.is_playing <= playing_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/pulse_breathing_opacity_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_breathing_opacity_test
// self-checking bench for the breathing-pulse opacity generator
// ----------------------------------------------------------------------------
// a queue of play/stop requests and time ticks feeds a clocked driver; every
// accepted transfer is run through a local model of the countdown, the
// playing flag and the last step time, and the result it predicts is queued
// a clocked monitor compares each output transfer field by field with the
// oldest prediction; a directed opening covers the corner cases, then random
// phases run under different register settings with random idling on both
// channels, one long output hold-off and a quiet tail
// ----------------------------------------------------------------------------
module pulse_breathing_opacity_test;
  import pbo_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 9;
  localparam int IdleLimit    = 3000;
  localparam int LongHold     = 300;
  localparam int TailCycles   = 30;
  localparam int RandPhases   = 10;
  localparam int PhaseItems   = 113;
  localparam int OpacityScale = 510;
  localparam int OpacityMax   = 255;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel, owned by the driver
  logic in_valid    = 1'b0;
  logic in_ready_o;
  in_t  in_data     = '0;

  // output channel, ready owned by the monitor
  logic res_ready   = 1'b0;
  logic out_valid_o;
  out_t out_data_o;

  // register write port, owned by the initial block
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx   = REG_ANIM_ENABLED;
  logic [CfgDataBits-1:0] cfg_wdata = '0;

  pulse_breathing_opacity uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (res_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // local copy of the block's registers and state
  // ---------------------------------------------------------------------------
  logic                  cfg_enabled       = 1'b0;
  logic [TotalBits-1:0]  cfg_total         = 16'd1;
  logic [TotalBits-1:0]  cfg_period        = '0;
  logic                  model_playing     = 1'b0;
  logic [15:0]           model_frames_left = '0;
  logic [TimeBits-1:0]   model_last_time   = '0;

  in_t  pending_items[$];
  out_t expected_results[$];
  int   mismatch_count = 0;

  // stimulus knobs shared with the driver and the monitor
  bit   quiet_tail = 1'b0;
  int   hold_asks  = 0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one step of the pulse: updates the local state and returns the result
  function automatic out_t next_pulse_result(input in_t item);
    out_t                res;
    logic                active;
    logic [TimeBits-1:0] elapsed;
    logic [31:0]         tri_dist;
    logic [31:0]         scaled;
    res    = '0;
    active = cfg_enabled && (cfg_total != 0);
    if (item.kind == KIND_PLAY) begin
      // a request equal to the current flag leaves everything alone
      if (item.play_request != model_playing) begin
        model_playing = item.play_request;
        if (item.play_request) begin
          // start loads the countdown, or 0 while disabled
          model_frames_left = active ? cfg_total : '0;
          model_last_time   = item.now_time;
        end else if (model_frames_left > cfg_total / 2) begin
          // stop past half-way reverses; a countdown above the total drops to 0
          model_frames_left = (model_frames_left > cfg_total) ?
                              '0 : cfg_total - model_frames_left;
        end
      end
    end else begin
      elapsed = item.now_time - model_last_time;
      if (active && !(!model_playing && model_frames_left == 0) &&
          elapsed >= TimeBits'(cfg_period)) begin
        if (model_playing && model_frames_left == 0) model_frames_left = cfg_total;
        if (model_frames_left > 0) model_frames_left = model_frames_left - 1'b1;
        model_last_time = item.now_time;
        res.advanced    = 1'b1;
      end
    end
    // triangular opacity, 0 while disabled or with the countdown above the total
    if (active && model_frames_left <= cfg_total) begin
      tri_dist = ((cfg_total - model_frames_left) < model_frames_left) ?
                 32'(cfg_total - model_frames_left) : 32'(model_frames_left);
      scaled   = tri_dist * OpacityScale / 32'(cfg_total);
      res.opacity = (scaled > OpacityMax) ? 8'(OpacityMax) : scaled[7:0];
    end
    res.is_playing = model_playing;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued items, idles in random bursts
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(next_pulse_result(in_data));
      end
      // the current slot is free once it is empty or being transferred now
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks results, stalls in random bursts and on request for long
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   hold_taken = 0;
  out_t want_res;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (out_valid_o && res_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result transfer with no prediction pending");
        end else begin
          want_res = expected_results.pop_front();
          if (out_data_o.advanced !== want_res.advanced)
            flag_mismatch($sformatf("advanced got %0d expected %0d",
                                    out_data_o.advanced, want_res.advanced));
          if (out_data_o.opacity !== want_res.opacity)
            flag_mismatch($sformatf("opacity got %0d expected %0d",
                                    out_data_o.opacity, want_res.opacity));
          if (out_data_o.is_playing !== want_res.is_playing)
            flag_mismatch($sformatf("is_playing got %0d expected %0d",
                                    out_data_o.is_playing, want_res.is_playing));
        end
      end
      if (hold_taken != hold_asks) begin
        // long hold-off so the block backs up and stalls its input
        hold_taken = hold_asks;
        stall_left = LongHold - 1;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer ends the run
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && res_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [TimeBits-1:0] stim_time = '0;

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataBits-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ANIM_ENABLED: cfg_enabled = data[0];
      REG_FRAME_TOTAL:  cfg_total   = data;
      REG_FRAME_PERIOD: cfg_period  = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input kind_e kind, input logic req, input logic [TimeBits-1:0] t);
    in_t item;
    item.kind         = kind;
    // play_request rides along on ticks too, where it is ignored
    item.play_request = (kind == KIND_PLAY) ? req : 1'($urandom_range(0, 1));
    item.now_time     = t;
    stim_time         = t;
    pending_items.push_back(item);
  endtask

  task automatic drain_results();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic add_random_item();
    logic [TimeBits-1:0] t;
    logic                req;
    kind_e               kind;
    t = stim_time;
    case ($urandom_range(0, 19))
      0:       t = $urandom;
      1:       t = t - $urandom_range(1, 1000);
      2, 3, 4: t = t + $urandom_range(0, cfg_period);
      default: t = t + cfg_period + $urandom_range(0, 4) - 2;
    endcase
    kind = ($urandom_range(0, 99) < 15) ? KIND_PLAY : KIND_TICK;
    req  = ($urandom_range(0, 9) < 7);
    add_item(kind, req, t);
  endtask

  initial begin
    logic [TotalBits-1:0] total_pick;
    logic [TotalBits-1:0] period_pick;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: disabled, start loads 0, repeated request, stop
    add_item(KIND_PLAY, 1'b1, 32'd5);
    add_item(KIND_TICK, 1'b0, 32'd9);
    add_item(KIND_PLAY, 1'b1, 32'd20);
    add_item(KIND_PLAY, 1'b0, 32'd21);
    drain_results();

    write_reg(REG_ANIM_ENABLED, 16'h0001);
    write_reg(REG_FRAME_TOTAL, 16'd10);
    write_reg(REG_FRAME_PERIOD, 16'd3);
    write_reg(REG_UNUSED, 16'hFFFF);
    // countdown across the timestamp wrap, too-early tick, reversal on stop
    add_item(KIND_PLAY, 1'b1, 32'hFFFF_FFF0);
    add_item(KIND_TICK, 1'b0, 32'hFFFF_FFF2);
    add_item(KIND_TICK, 1'b0, 32'hFFFF_FFF3);
    add_item(KIND_TICK, 1'b0, 32'h0000_0002);
    add_item(KIND_TICK, 1'b0, 32'd5);
    add_item(KIND_TICK, 1'b0, 32'd8);
    add_item(KIND_PLAY, 1'b0, 32'd9);
    add_item(KIND_TICK, 1'b0, 32'd12);
    add_item(KIND_TICK, 1'b0, 32'hFFFF_FFFF);
    add_item(KIND_PLAY, 1'b1, 32'h0000_0000);
    drain_results();

    // shrink the total below the live countdown: opacity 0, stop clears it
    write_reg(REG_FRAME_TOTAL, 16'd4);
    add_item(KIND_PLAY, 1'b1, 32'd10);
    add_item(KIND_TICK, 1'b0, 32'd20);
    add_item(KIND_PLAY, 1'b0, 32'd21);
    drain_results();

    // zero total behaves as disabled
    write_reg(REG_FRAME_TOTAL, 16'd0);
    add_item(KIND_PLAY, 1'b1, 32'h8000_0000);
    add_item(KIND_TICK, 1'b0, 32'h8001_0000);
    add_item(KIND_PLAY, 1'b0, 32'h8001_0001);
    drain_results();

    // widest total and period
    write_reg(REG_FRAME_TOTAL, 16'hFFFF);
    write_reg(REG_FRAME_PERIOD, 16'hFFFF);
    add_item(KIND_PLAY, 1'b1, 32'h7FFF_0000);
    add_item(KIND_TICK, 1'b0, 32'h7FFF_FFFE);
    add_item(KIND_TICK, 1'b0, 32'h7FFF_FFFF);
    add_item(KIND_PLAY, 1'b0, 32'h8000_0000);
    drain_results();

    // random phases, each under its own register setting
    for (int phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0:       total_pick = 16'd1;
        1:       total_pick = TotalBits'($urandom_range(2, 12));
        2:       total_pick = 16'd9;
        3:       total_pick = 16'hFFFF;
        4:       total_pick = 16'd0;
        5:       total_pick = TotalBits'($urandom_range(1, 65535));
        6:       total_pick = TotalBits'($urandom_range(2, 40));
        7:       total_pick = 16'd2;
        default: total_pick = TotalBits'($urandom_range(1, 300));
      endcase
      case (phase % 4)
        0:       period_pick = 16'd0;
        1:       period_pick = TotalBits'($urandom_range(1, 8));
        2:       period_pick = 16'hFFFF;
        default: period_pick = TotalBits'($urandom_range(0, 65535));
      endcase
      // upper data bits are don't-care for the enable
      write_reg(REG_ANIM_ENABLED, {15'($urandom), (phase != 2)});
      write_reg(REG_FRAME_TOTAL, total_pick);
      write_reg(REG_FRAME_PERIOD, period_pick);
      if (phase == 3) hold_asks++;
      if (phase == RandPhases - 1) quiet_tail = 1'b1;
      for (int n = 0; n < PhaseItems; n++) add_random_item();
      drain_results();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
